### src/dhti_pkg.sv
// Shared types and constants for the double-hashing table insert block.
package dhti_pkg;

    localparam int INDEX_BITS  = 6;
    localparam int KEY_BITS    = 12;
    localparam int TABLE_SLOTS = 1 << INDEX_BITS;
    localparam int STEP_BITS   = KEY_BITS - INDEX_BITS;
    localparam int COUNT_BITS  = INDEX_BITS + 1;
    localparam int SUM_BITS    = 32;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [0:0]            opcode;
        logic [KEY_BITS-1:0]   key;
        logic [INDEX_BITS-1:0] slot_select;
    } req_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] slot;
        logic [KEY_BITS-1:0]   slot_key;
        logic                  slot_used;
        logic [COUNT_BITS-1:0] probes;
        logic [SUM_BITS-1:0]   probe_total;
        logic                  table_full;
    } rsp_t;

    // Position on the probe path: current slot and number of moves taken.
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [COUNT_BITS-1:0] count;
    } probe_pos_t;

endpackage

### src/dhti_table.sv
// Slot storage: occupied flags in flops and the key memory with registered read.
module dhti_table
    import dhti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [INDEX_BITS-1:0] addr,
    input  logic                  wr_en,
    input  logic [KEY_BITS-1:0]   wr_key,
    output logic                  used,
    output logic [KEY_BITS-1:0]   rd_key
);

    logic [TABLE_SLOTS-1:0] mark_reg;
    logic [KEY_BITS-1:0]    key_mem [TABLE_SLOTS];

    // Set the occupied flag of the slot being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else if (wr_en)
        begin
            mark_reg[addr] <= 1'b1;
        end
    end

    // Write the key and register the read of the addressed slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[addr] <= wr_key;
        end
        rd_key <= key_mem[addr];
    end

    assign used = mark_reg[addr];

endmodule

### src/dhti_step_unit.sv
// Shared probe step: advance the slot by the odd step modulo the table size.
module dhti_step_unit
    import dhti_pkg::*;
(
    input  probe_pos_t            cur,
    input  logic [STEP_BITS-1:0]  step,
    output probe_pos_t            nxt
);

    logic [INDEX_BITS-1:0] step_idx;

    // Force the step odd and fold it into the index width
    always_comb
    begin
        step_idx    = INDEX_BITS'({step[STEP_BITS-1:1], 1'b1});
        nxt.idx     = cur.idx + step_idx;
        nxt.count   = cur.count + COUNT_BITS'(1);
    end

endmodule

### src/double_hash_table_insert.sv
// Top level: sequencer, running probe total and result register of the hash table.
//
// Usage:
//   Requests arrive on req_valid / req_stall / req. A transaction is taken at a
//   rising edge with req_valid high and req_stall low. An insert (opcode 0)
//   places the key by double hashing: home slot is the low index bits, the step
//   is the high key bits forced odd. A read (opcode 1) returns one slot.
//   Every request gives exactly one result on rsp_valid / rsp_stall / rsp.
// Timing:
//   One request is worked at a time; req_stall stays high until it is done.
//   The probe loop checks one slot per cycle through the shared step adder.
//   An insert moves from its home slot by the step through S_PROBE until a
//   free slot turns up, then loads its result in S_FINISH. A read waits in
//   S_RDWAIT for one key memory read; an insert into a full table goes to S_FINISH.
//   The next request is taken the cycle after the result is loaded.
// Reset:
//   rst_n clears all occupied flags, the used count and the probe total.
// Stall:
//   A result waits in the output register while rsp_stall is high; a new
//   request may still be taken and worked, and holds at its end until the
//   output register frees.
module double_hash_table_insert
    import dhti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROBE  = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    probe_pos_t            pos_reg, pos_next;
    probe_pos_t            step_pos;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  read_reg, read_next;
    logic                  full_reg, full_next;
    logic [COUNT_BITS-1:0] probes_reg, probes_next;
    logic [COUNT_BITS-1:0] used_count_reg, used_count_next;
    logic [SUM_BITS-1:0]   total_reg, total_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  wr_en;
    logic                  slot_used;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  out_free;
    logic [SUM_BITS:0]     sum_wide;

    dhti_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .addr   (pos_reg.idx),
        .wr_en  (wr_en),
        .wr_key (key_reg),
        .used   (slot_used),
        .rd_key (rd_key)
    );

    dhti_step_unit u_step (
        .cur  (pos_reg),
        .step (step_reg),
        .nxt  (step_pos)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign wr_en    = (state_reg == S_PROBE) && !slot_used;
    assign sum_wide = {1'b0, total_reg} + (SUM_BITS + 1)'(probes_reg);

    // Sequence one request through probe, read and result load
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        key_next        = key_reg;
        read_next       = read_reg;
        full_next       = full_reg;
        probes_next     = probes_reg;
        used_count_next = used_count_reg;
        total_next      = total_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    key_next    = req.key;
                    step_next   = req.key[KEY_BITS-1:INDEX_BITS];
                    read_next   = (req.opcode == OP_READ);
                    full_next   = 1'b0;
                    probes_next = '0;
                    pos_next.count = '0;
                    if (req.opcode == OP_READ)
                    begin
                        pos_next.idx = req.slot_select;
                        state_next   = S_RDWAIT;
                    end
                    else if (used_count_reg == COUNT_BITS'(TABLE_SLOTS))
                    begin
                        pos_next.idx = '0;
                        full_next    = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        pos_next.idx = req.key[INDEX_BITS-1:0];
                        state_next   = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (!slot_used)
                begin
                    // Claim the free slot; home counts as one probe
                    probes_next     = (pos_reg.count == '0) ? COUNT_BITS'(1) : pos_reg.count;
                    used_count_next = used_count_reg + COUNT_BITS'(1);
                    state_next      = S_FINISH;
                end
                else
                begin
                    pos_next = step_pos;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.slot        = pos_reg.idx;
                    rsp_next.table_full  = full_reg;
                    rsp_next.probes      = probes_reg;
                    if (read_reg)
                    begin
                        rsp_next.slot_used = slot_used;
                        rsp_next.slot_key  = slot_used ? rd_key : '0;
                    end
                    else
                    begin
                        rsp_next.slot_used = !full_reg;
                        rsp_next.slot_key  = full_reg ? '0 : key_reg;
                        // Saturate the running probe total
                        if (!full_reg)
                        begin
                            total_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                        end
                    end
                    rsp_next.probe_total = (read_reg || full_reg) ? total_reg : total_next;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            total_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            total_reg      <= total_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Working payload and result register
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        key_reg    <= key_next;
        read_reg   <= read_next;
        full_reg   <= full_next;
        probes_reg <= probes_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### src/dhti_checker.sv
// Port-level checks for the double-hashing table insert block.
module dhti_checker
    import dhti_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result dropped or changed");

    // Refuse new work right after a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // A refused insert stores nothing and counts no probes
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.table_full |-> rsp.probes == '0 && !rsp.slot_used
            && rsp.slot_key == '0)
        else $error("full-table result not empty");

    // An empty slot reports a zero key
    a_empty_key: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.slot_used |-> rsp.slot_key == '0)
        else $error("unused slot shows a key");

    // A counted insert always lands in an occupied slot
    a_insert_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.probes != '0 |-> rsp.slot_used && !rsp.table_full)
        else $error("insert result not marked used");

endmodule

bind double_hash_table_insert dhti_checker u_dhti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### tb/sv/double_hash_table_insert_tb.sv
// Self-checking testbench for the double-hashing table insert block.
module double_hash_table_insert_tb
    import dhti_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 630;
    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 80;

    // Tracks table contents and the queue of results still owed by the block.
    class table_scoreboard;
        bit                  occupied [TABLE_SLOTS];
        logic [KEY_BITS-1:0] stored [TABLE_SLOTS];
        int unsigned         used_count;
        logic [SUM_BITS-1:0] probe_sum;
        rsp_t                awaited_rsp [$];
        int unsigned         mismatches;

        function new();
            used_count = 0;
            probe_sum  = '0;
            mismatches = 0;
            foreach (occupied[i])
                occupied[i] = 1'b0;
        endfunction

        // Work out the result of one accepted transaction and queue it.
        function void note_request(req_t r);
            rsp_t                  e;
            logic [INDEX_BITS-1:0] idx;
            logic [INDEX_BITS-1:0] stride;
            logic [COUNT_BITS-1:0] moves;
            logic [SUM_BITS:0]     widened;
            bit                    found;
            e = '0;
            if (r.opcode == OP_READ)
            begin
                e.slot      = r.slot_select;
                e.slot_used = occupied[r.slot_select];
                e.slot_key  = occupied[r.slot_select] ? stored[r.slot_select] : '0;
            end
            else if (used_count >= TABLE_SLOTS)
            begin
                e.table_full = 1'b1;
            end
            else
            begin
                idx   = r.key[INDEX_BITS-1:0];
                moves = '0;
                found = !occupied[idx];
                if (!found)
                begin
                    // Step by the high key bits forced odd until a free slot turns up.
                    stride = r.key[KEY_BITS-1:INDEX_BITS] | STEP_BITS'(1);
                    for (int n = 1; n <= TABLE_SLOTS && !found; n++)
                    begin
                        idx   = idx + stride;
                        moves = COUNT_BITS'(n);
                        found = !occupied[idx];
                    end
                end
                if (found)
                begin
                    occupied[idx] = 1'b1;
                    stored[idx]   = r.key;
                    used_count++;
                    e.probes    = (moves == '0) ? COUNT_BITS'(1) : moves;
                    widened     = {1'b0, probe_sum} + (SUM_BITS + 1)'(e.probes);
                    probe_sum   = widened[SUM_BITS] ? '1 : widened[SUM_BITS-1:0];
                    e.slot      = idx;
                    e.slot_key  = r.key;
                    e.slot_used = 1'b1;
                end
                else
                begin
                    e.table_full = 1'b1;
                end
            end
            e.probe_total = probe_sum;
            awaited_rsp.push_back(e);
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned seen);
            if (want != seen)
            begin
                $error("%s: expected %0d, actual %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(rsp_t got);
            rsp_t e;
            if (awaited_rsp.size() == 0)
            begin
                $error("result transaction with nothing expected: slot %0d", got.slot);
                mismatches++;
                return;
            end
            e = awaited_rsp.pop_front();
            compare_field("slot", e.slot, got.slot);
            compare_field("slot_key", e.slot_key, got.slot_key);
            compare_field("slot_used", e.slot_used, got.slot_used);
            compare_field("probes", e.probes, got.probes);
            compare_field("probe_total", e.probe_total, got.probe_total);
            compare_field("table_full", e.table_full, got.table_full);
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int unsigned send_idle = 30;
    int unsigned recv_idle = 80;
    int unsigned quiet_cycles = 0;

    table_scoreboard sb = new();

    double_hash_table_insert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Check results, stall the result side at random, watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // Offer one transaction, with random idle cycles ahead, and hold it until taken.
    task automatic send_request(req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(r);
    endtask

    function automatic req_t insert_req(logic [KEY_BITS-1:0] k);
        req_t r;
        r.opcode      = OP_INSERT;
        r.key         = k;
        r.slot_select = ~k[INDEX_BITS-1:0];
        return r;
    endfunction

    function automatic req_t read_req(logic [INDEX_BITS-1:0] s);
        req_t r;
        r.opcode      = OP_READ;
        r.key         = KEY_BITS'($urandom);
        r.slot_select = s;
        return r;
    endfunction

    // Insert to fill_cap and into a full table; crowd homes; read only written slots.
    function automatic req_t next_random_request(int unsigned fill_cap);
        req_t        r;
        int unsigned pick;
        logic [INDEX_BITS-1:0] s;
        pick = $urandom_range(99);
        if (sb.used_count == 0 || (sb.used_count < fill_cap && pick < 50)
            || (sb.used_count == TABLE_SLOTS && pick < 30))
        begin
            r = insert_req(KEY_BITS'($urandom));
            r.slot_select = INDEX_BITS'($urandom);
            if ($urandom_range(1))
                r.key[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(3));
        end
        else
        begin
            do
                s = INDEX_BITS'($urandom);
            while (!sb.occupied[s]);
            r = read_req(s);
        end
        return r;
    endfunction

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: home hits, collisions with smallest and largest steps,
        // duplicate key, key zero, all-ones key, reads of written slots.
        send_request(insert_req(12'h000));
        send_request(insert_req(12'h040));
        send_request(insert_req(12'hFC0));
        send_request(insert_req(12'h001));
        send_request(insert_req(12'h080));
        send_request(insert_req(12'h000));
        send_request(insert_req(12'hFFF));
        send_request(read_req(6'd0));
        send_request(read_req(6'd63));
        send_request(read_req(6'd62));
        send_request(read_req(6'd1));
        send_request(insert_req(12'hAAA));
        send_request(insert_req(12'h555));
        send_request(read_req(6'd4));
        send_request(read_req(6'd42));

        // Random: sender idles lightly, receiver heavily.
        repeat (ITEMS_PER_PHASE) send_request(next_random_request(24));

        // Random: sender idles heavily, receiver lightly.
        send_idle = 80;
        recv_idle = 30;
        repeat (ITEMS_PER_PHASE) send_request(next_random_request(48));

        // Random: no idling on either side; table fills, then refuses inserts.
        send_idle = 0;
        recv_idle = 0;
        repeat (ITEMS_PER_PHASE) send_request(next_random_request(TABLE_SLOTS));
        req_valid <= 1'b0;

        while (sb.awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.awaited_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
